FILE: rtl/rmfc_pkg.sv
// ----------------------------------------------------------------------------
// rmfc_pkg
// Shared types and constants of the half-duplex bus master frame controller.
// ----------------------------------------------------------------------------
package rmfc_pkg;

    localparam int unsigned BYTE_W = 8;

    // bus mode codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TX   = 2'd2;

    // frame byte count at which the length byte has just been stored
    localparam int unsigned LEN_BYTE_COUNT = 2;

    // input word layout, lowest bit up
    localparam int unsigned IN_W  = 24;
    // output word layout, lowest bit up
    localparam int unsigned OUT_W = 24;

    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic rd;       // read the next frame byte from the store
        logic advance;  // step to the next frame byte
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit_now; // word being accepted completes a frame for this station
        logic last;     // result on the output is the final one of its poll
    } ctrl_status_t;

endpackage

FILE: rtl/rs485_master_frame_controller.sv
// One poll word in, then one result word out, or one per byte when the poll
// completes a frame addressed to this station. A single result is offered in
// the cycle after the poll is accepted. When a poll emits a frame, every byte
// is read from the frame store through its registered read port before it is
// shown. The next poll is taken only after the last result word of the
// current one has been accepted. station_address may be written only while
// no poll is in flight. frame_valid travels in m_tuser, the final result of a
// poll carries m_tlast.
// ----------------------------------------------------------------------------
// rs485_master_frame_controller
// Half-duplex bus master: idle/receive/transmit sequencing, frame capture
// with station address filtering, and byte-wise frame output.
// ----------------------------------------------------------------------------
module rs485_master_frame_controller #(
    parameter int unsigned FRAME_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,   // station_address
    input  logic        s_tvalid,
    output logic        s_tready,
    // rx_valid, rx_byte[8], send_request, send_length[8], tx_complete, pad
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // driver_enable, start_tx, tx_length[8], rx_taken, frame_byte[8],
    // awaiting_reply, pad
    output logic [23:0] m_tdata,
    output logic [0:0]  m_tuser,     // frame_valid
    output logic        m_tlast      // frame_last
);

    rmfc_pkg::ctrl_cmd_t    cmd;
    rmfc_pkg::ctrl_status_t status;
    logic                   frame_valid;

    rmfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rmfc_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_word         (s_tdata),
        .out_word        (m_tdata),
        .out_frame_valid (frame_valid),
        .out_last        (m_tlast),
        .cmd             (cmd),
        .status          (status)
    );

    assign m_tuser = frame_valid;

endmodule

FILE: rtl/rmfc_ram.sv
// ----------------------------------------------------------------------------
// rmfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmfc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rmfc_ctrl.sv
// ----------------------------------------------------------------------------
// rmfc_ctrl
// Handshake sequencer: takes one poll word, then hands out its result words
// (one, or one per byte of an accepted frame) before taking the next poll.
// ----------------------------------------------------------------------------
module rmfc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  rmfc_pkg::ctrl_status_t status,
    output rmfc_pkg::ctrl_cmd_t   cmd
);

    localparam logic [1:0] ST_IN    = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_SHOW  = 2'd2;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.rd      = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            ST_IN: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = status.emit_now ? ST_FETCH : ST_SHOW;
                end
            end
            ST_FETCH: begin
                cmd.rd     = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (status.last) begin
                        state_next = ST_IN;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IN;
            end
        endcase
    end

endmodule

FILE: rtl/rmfc_datapath.sv
// ----------------------------------------------------------------------------
// rmfc_datapath
// Bus mode, send/reply bookkeeping, frame store and result word registers.
// ----------------------------------------------------------------------------
module rmfc_datapath #(
    parameter int unsigned FRAME_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rmfc_pkg::BYTE_W-1:0]   cfg_wdata,
    input  logic [rmfc_pkg::IN_W-1:0]     in_word,
    output logic [rmfc_pkg::OUT_W-1:0]    out_word,
    output logic                          out_frame_valid,
    output logic                          out_last,
    input  rmfc_pkg::ctrl_cmd_t           cmd,
    output rmfc_pkg::ctrl_status_t        status
);

    localparam int unsigned AW = $clog2(FRAME_DEPTH);
    localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);
    localparam int unsigned BW = rmfc_pkg::BYTE_W;

    // input word fields
    logic          rx_valid;
    logic [BW-1:0] rx_byte;
    logic          send_request;
    logic [BW-1:0] send_length;
    logic          tx_complete;

    assign rx_valid     = in_word[0];
    assign rx_byte      = in_word[8:1];
    assign send_request = in_word[9];
    assign send_length  = in_word[17:10];
    assign tx_complete  = in_word[18];

    logic [1:0]    mode_reg, mode_next;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [BW-1:0] exp_len_reg, exp_len_next;
    logic          send_pending_reg, send_pending_next;
    logic [BW-1:0] pending_len_reg, pending_len_next;
    logic          reply_awaited_reg, reply_awaited_next;
    logic [BW-1:0] station_addr_reg;
    logic [BW-1:0] first_byte_reg, first_byte_next;

    // result word registers
    logic          drv_en_reg, drv_en_next;
    logic          start_tx_reg, start_tx_next;
    logic [BW-1:0] tx_length_reg, tx_length_next;
    logic          rx_taken_reg, rx_taken_next;
    logic          frame_valid_reg, frame_valid_next;
    logic [AW-1:0] last_idx_reg, last_idx_next;
    logic [AW-1:0] emit_idx_reg;

    logic          store_we;
    logic [BW-1:0] store_rdata;
    logic [CW-1:0] cnt_inc;
    logic          frame_end;
    logic          addr_match;

    assign cnt_inc = byte_count_reg + CW'(1);

    always_comb begin
        mode_next          = mode_reg;
        byte_count_next    = byte_count_reg;
        exp_len_next       = exp_len_reg;
        send_pending_next  = send_pending_reg | send_request;
        pending_len_next   = send_request ? send_length : pending_len_reg;
        reply_awaited_next = reply_awaited_reg | send_request;
        first_byte_next    = first_byte_reg;
        start_tx_next      = 1'b0;
        tx_length_next     = '0;
        rx_taken_next      = 1'b0;
        frame_valid_next   = 1'b0;
        last_idx_next      = byte_count_reg[AW-1:0];
        store_we           = 1'b0;
        frame_end          = 1'b0;
        addr_match         = 1'b0;

        unique case (mode_reg)
            rmfc_pkg::MODE_RX: begin
                if (rx_valid) begin
                    rx_taken_next   = 1'b1;
                    store_we        = 1'b1;
                    byte_count_next = cnt_inc;
                    if (byte_count_reg == '0) begin
                        first_byte_next = rx_byte;
                    end
                    if (cnt_inc == CW'(rmfc_pkg::LEN_BYTE_COUNT)) begin
                        exp_len_next = rx_byte;
                    end
                    frame_end  = (BW'(cnt_inc) == exp_len_next) ||
                                 (cnt_inc >= CW'(FRAME_DEPTH));
                    addr_match = ((byte_count_reg == '0) ? rx_byte : first_byte_reg)
                                 == station_addr_reg;
                    if (frame_end) begin
                        if (addr_match) begin
                            frame_valid_next   = 1'b1;
                            reply_awaited_next = 1'b0;
                        end
                        byte_count_next = '0;
                        mode_next       = rmfc_pkg::MODE_IDLE;
                    end
                end
            end
            rmfc_pkg::MODE_TX: begin
                if (tx_complete && !send_pending_next) begin
                    mode_next = rmfc_pkg::MODE_IDLE;
                end
            end
            default: begin
                mode_next = rmfc_pkg::MODE_IDLE;
                if (rx_valid) begin
                    mode_next    = rmfc_pkg::MODE_RX;
                    exp_len_next = BW'(FRAME_DEPTH);
                end
                // pending send wins over a waiting byte
                if (send_pending_next) begin
                    start_tx_next     = 1'b1;
                    tx_length_next    = pending_len_next;
                    send_pending_next = 1'b0;
                    mode_next         = rmfc_pkg::MODE_TX;
                end
            end
        endcase

        drv_en_next = (mode_next == rmfc_pkg::MODE_TX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= rmfc_pkg::MODE_IDLE;
            byte_count_reg    <= '0;
            exp_len_reg       <= BW'(FRAME_DEPTH);
            send_pending_reg  <= 1'b0;
            pending_len_reg   <= '0;
            reply_awaited_reg <= 1'b0;
            station_addr_reg  <= '0;
            frame_valid_reg   <= 1'b0;
            emit_idx_reg      <= '0;
        end else begin
            if (cfg_we) begin
                station_addr_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                mode_reg          <= mode_next;
                byte_count_reg    <= byte_count_next;
                exp_len_reg       <= exp_len_next;
                send_pending_reg  <= send_pending_next;
                pending_len_reg   <= pending_len_next;
                reply_awaited_reg <= reply_awaited_next;
                frame_valid_reg   <= frame_valid_next;
                emit_idx_reg      <= '0;
            end else if (cmd.advance) begin
                emit_idx_reg <= emit_idx_reg + AW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            first_byte_reg <= first_byte_next;
            drv_en_reg     <= drv_en_next;
            start_tx_reg   <= start_tx_next;
            tx_length_reg  <= tx_length_next;
            rx_taken_reg   <= rx_taken_next;
            last_idx_reg   <= last_idx_next;
        end
    end

    rmfc_ram #(
        .WIDTH (BW),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.accept && store_we),
        .waddr (byte_count_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd),
        .raddr (emit_idx_reg),
        .rdata (store_rdata)
    );

    assign status.emit_now = frame_valid_next;
    assign status.last     = !frame_valid_reg || (emit_idx_reg == last_idx_reg);

    assign out_frame_valid = frame_valid_reg;
    assign out_last        = status.last;
    assign out_word = {4'b0000,
                       reply_awaited_reg,
                       frame_valid_reg ? store_rdata : '0,
                       rx_taken_reg,
                       tx_length_reg,
                       start_tx_reg,
                       drv_en_reg};

endmodule
